// File: rtl/core/rvg_pkg.sv
// ----------------------------------------------------------------------------
// rvg_pkg
// Shared types and constants of the radial vignette gain pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rvg_pkg;

  // Full scale of a color sample and of the gain code.
  localparam logic [7:0] MAXV = 8'd255;

  // Squared normalized radius in Q16 is limited so that 1 + t stays below 2^48.
  localparam int unsigned T_W = 48;
  localparam logic [T_W-1:0] TCAP = 48'hFFFF_FFFE_FFFF;
  localparam logic [T_W-1:0] ONE_Q16 = 48'h0000_0001_0000;

  // Gain in Q16 is the root of a value below 2^64.
  localparam int unsigned G_W = 32;

  // Rounding term and saturation point of the final scaling by 255 * 2^16.
  localparam logic [48:0] RND_HALF = 49'd8355840;
  localparam logic [32:0] SAT_Y = 33'd65280;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_FALLOFF = 2'd2,
    REG_ENABLE  = 2'd3
  } reg_idx_e;

  // Payload that rides along the pipeline; cal marks the corner-gain probe.
  typedef struct packed {
    logic       cal;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

endpackage

`default_nettype wire

// File: rtl/core/rvg_if.sv
// ----------------------------------------------------------------------------
// rvg_if
// Request channels of the vignette block: pixel in and corrected pixel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvg_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [7:0]            blue_in;
  logic [7:0]            green_in;
  logic [7:0]            red_in;

  modport source (output valid, col, row, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, col, row, blue_in, green_in, red_in, output ready);
endinterface

interface rvg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] gain_code;

  modport source (output valid, blue_out, green_out, red_out, gain_code, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, gain_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rvg_div.sv
// ----------------------------------------------------------------------------
// rvg_div
// Pipelined restoring divider: t = min(floor(s * 2^32 / den), TCAP).
// ----------------------------------------------------------------------------
`default_nettype none

module rvg_div
  import rvg_pkg::*;
#(
  parameter int unsigned S_W   = 27,
  parameter int unsigned DEN_W = 56
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             flush_i,
  input  wire logic             vld_i,
  input  wire logic [S_W-1:0]   s_i,
  input  wire pix_t             pix_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  vld_o,
  output logic [T_W-1:0]        t_o,
  output pix_t                  pix_o
);

  localparam int unsigned NUM_W = S_W + 32;

  logic             vld_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [T_W-1:0]   quo_q [NUM_W];
  logic             ovf_q [NUM_W];
  logic [S_W-1:0]   s_q   [NUM_W];
  pix_t             pix_q [NUM_W];

  logic             vld_in [NUM_W];
  logic [DEN_W-1:0] rem_in [NUM_W];
  logic [T_W-1:0]   quo_in [NUM_W];
  logic             ovf_in [NUM_W];
  logic [S_W-1:0]   s_in   [NUM_W];
  pix_t             pix_in [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    localparam int unsigned P = NUM_W - 1 - k;
    logic             nb;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in[k] = vld_i;
      assign rem_in[k] = '0;
      assign quo_in[k] = '0;
      assign ovf_in[k] = 1'b0;
      assign s_in[k]   = s_i;
      assign pix_in[k] = pix_i;
    end else begin : g_next
      assign vld_in[k] = vld_q[k-1];
      assign rem_in[k] = rem_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign ovf_in[k] = ovf_q[k-1];
      assign s_in[k]   = s_q[k-1];
      assign pix_in[k] = pix_q[k-1];
    end

    // The numerator is s followed by 32 zero bits.
    if (P >= 32) begin : g_sbit
      assign nb = s_in[k][P-32];
    end else begin : g_zbit
      assign nb = 1'b0;
    end

    assign trial = {rem_in[k], nb};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (flush_i) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q[k] <= {quo_in[k][T_W-2:0], ge};
        ovf_q[k] <= ovf_in[k] | quo_in[k][T_W-1];
        s_q[k]   <= s_in[k];
        pix_q[k] <= pix_in[k];
      end
    end
  end

  logic           vld_t_q;
  logic [T_W-1:0] t_q;
  pix_t           pix_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t_q <= 1'b0;
    end else if (flush_i) begin
      vld_t_q <= 1'b0;
    end else if (en_i) begin
      vld_t_q <= vld_q[NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= (ovf_q[NUM_W-1] || (quo_q[NUM_W-1] > TCAP)) ? TCAP : quo_q[NUM_W-1];
      pix_t_q <= pix_q[NUM_W-1];
    end
  end

  assign vld_o = vld_t_q;
  assign t_o   = t_q;
  assign pix_o = pix_t_q;

endmodule

`default_nettype wire

// File: rtl/core/rvg_sqrt.sv
// ----------------------------------------------------------------------------
// rvg_sqrt
// Pipelined integer square root of (2^16 + t) * 2^16, one result bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rvg_sqrt
  import rvg_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           flush_i,
  input  wire logic           vld_i,
  input  wire logic [T_W-1:0] t_i,
  input  wire pix_t           pix_i,
  output logic                vld_o,
  output logic [G_W-1:0]      g_o,
  output pix_t                pix_o
);

  localparam int unsigned STEPS = G_W;

  logic        vld_q [STEPS+1];
  logic [63:0] v_q   [STEPS+1];
  logic [63:0] r_q   [STEPS+1];
  pix_t        pix_q [STEPS+1];

  logic [T_W-1:0] g2;
  assign g2 = t_i + ONE_Q16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (flush_i) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]   <= {g2, 16'h0000};
      r_q[0]   <= '0;
      pix_q[0] <= pix_i;
    end
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam logic [63:0] BB = 64'd1 << (64 - 2 * j);
    logic [63:0] rb;
    logic        ge;

    assign rb = r_q[j-1] + BB;
    assign ge = (v_q[j-1] >= rb);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (flush_i) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j]   <= ge ? (v_q[j-1] - rb) : v_q[j-1];
        r_q[j]   <= ge ? ((r_q[j-1] >> 1) + BB) : (r_q[j-1] >> 1);
        pix_q[j] <= pix_q[j-1];
      end
    end
  end

  assign vld_o = vld_q[STEPS];
  assign g_o   = r_q[STEPS][G_W-1:0];
  assign pix_o = pix_q[STEPS];

endmodule

`default_nettype wire

// File: rtl/core/rvg_gain.sv
// ----------------------------------------------------------------------------
// rvg_gain
// Quantizes the gain against the corner gain, then scales or passes the channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rvg_gain
  import rvg_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           flush_i,
  input  wire logic           vld_i,
  input  wire logic [G_W-1:0] g_i,
  input  wire pix_t           pix_i,
  input  wire logic [G_W-1:0] gmax_i,
  input  wire logic           enable_i,
  output logic                vld_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          green_o,
  output logic [7:0]          red_o,
  output logic [7:0]          code_o
);

  localparam int unsigned N_W = 42;
  localparam int unsigned QB  = 8;

  // Numerator of the code: 510 * g + gmax.
  logic           vld0_q;
  logic [N_W-1:0] n0_q;
  pix_t           pix0_q;

  // Saturation check against 2 * gmax * 256.
  logic           vld1_q;
  logic [N_W-1:0] n1_q;
  logic           sat1_q;
  pix_t           pix1_q;

  logic           vldb_q [QB];
  logic [N_W-1:0] remb_q [QB];
  logic [QB-1:0]  quob_q [QB];
  logic           satb_q [QB];
  pix_t           pixb_q [QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (flush_i) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= vld_i;
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q   <= N_W'(g_i) * N_W'(510) + N_W'(gmax_i);
      pix0_q <= pix_i;
      n1_q   <= n0_q;
      sat1_q <= (n0_q >= {1'b0, gmax_i, 9'b0});
      pix1_q <= pix0_q;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_qbit
    localparam int unsigned BIT = QB - 1 - j;
    logic           vld_in;
    logic [N_W-1:0] rem_in;
    logic [QB-1:0]  quo_in;
    logic           sat_in;
    pix_t           pix_in;
    logic [N_W-1:0] dsh;
    logic           ge;

    if (j == 0) begin : g_first
      assign vld_in = vld1_q;
      assign rem_in = n1_q;
      assign quo_in = '0;
      assign sat_in = sat1_q;
      assign pix_in = pix1_q;
    end else begin : g_next
      assign vld_in = vldb_q[j-1];
      assign rem_in = remb_q[j-1];
      assign quo_in = quob_q[j-1];
      assign sat_in = satb_q[j-1];
      assign pix_in = pixb_q[j-1];
    end

    assign dsh = N_W'(gmax_i) << (BIT + 1);
    assign ge  = !sat_in && (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vldb_q[j] <= 1'b0;
      end else if (flush_i) begin
        vldb_q[j] <= 1'b0;
      end else if (en_i) begin
        vldb_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        remb_q[j] <= ge ? (rem_in - dsh) : rem_in;
        quob_q[j] <= {quo_in[QB-2:0], ge};
        satb_q[j] <= sat_in;
        pixb_q[j] <= pix_in;
      end
    end
  end

  logic [7:0] code_c;
  logic [7:0] chan_c [3];
  assign code_c    = satb_q[QB-1] ? MAXV : quob_q[QB-1];
  assign chan_c[0] = pixb_q[QB-1].blue;
  assign chan_c[1] = pixb_q[QB-1].green;
  assign chan_c[2] = pixb_q[QB-1].red;

  // Scaling stages: p * code, then times gmax, then round and divide by 255 * 2^16.
  logic        vld2_q, vld3_q, vld4_q, vld5_q;
  logic [7:0]  code2_q, code3_q, code4_q, code5_q;
  logic [7:0]  p2_q [3];
  logic [7:0]  p3_q [3];
  logic [7:0]  p4_q [3];
  logic [15:0] prod2_q [3];
  logic [47:0] x3_q [3];
  logic [32:0] y4_q [3];
  logic [7:0]  out5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (flush_i) begin
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vldb_q[QB-1];
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [48:0] sum4;
    logic [16:0] div5;

    assign sum4 = {1'b0, x3_q[c]} + RND_HALF;
    // For y below 65280, floor(y / 255) equals (y + y / 256 + 1) / 256.
    assign div5 = {1'b0, y4_q[c][15:0]} + {9'b0, y4_q[c][15:8]} + 17'd1;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p2_q[c]    <= chan_c[c];
        prod2_q[c] <= 16'(code_c) * 16'(chan_c[c]);
        p3_q[c]    <= p2_q[c];
        x3_q[c]    <= 48'(prod2_q[c]) * 48'(gmax_i);
        p4_q[c]    <= p3_q[c];
        y4_q[c]    <= sum4[48:16];
        if (!enable_i) begin
          out5_q[c] <= p4_q[c];
        end else if (y4_q[c] >= SAT_Y) begin
          out5_q[c] <= MAXV;
        end else begin
          out5_q[c] <= div5[15:8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code2_q <= code_c;
      code3_q <= code2_q;
      code4_q <= code3_q;
      code5_q <= code4_q;
    end
  end

  assign vld_o   = vld5_q;
  assign blue_o  = out5_q[0];
  assign green_o = out5_q[1];
  assign red_o   = out5_q[2];
  assign code_o  = code5_q;

endmodule

`default_nettype wire

// File: rtl/core/radial_vignette_gain_pixel.sv
// ----------------------------------------------------------------------------
// radial_vignette_gain_pixel
// Per-pixel radial vignette correction with a gain quantized to the corner.
// ----------------------------------------------------------------------------
// A pixel request on px_i carries its column, row and three samples; the
// corrected samples and the 8-bit gain code leave on px_o in the same order.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
// The datapath is one pipeline of 2 + (2*COORD_BITS + 36) + 33 + 14 stages;
// the long divider for the squared radius sets that depth. A new pixel is
// taken in every cycle while the pipeline advances and the block is in S_RUN.
// After reset and after every configuration write the block runs the corner
// pixel through the pipeline to learn the corner gain; ready stays low until
// that gain is known.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and px_i.ready drops in the same cycle; no request is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_vignette_gain_pixel
  import rvg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rvg_in_if.sink           px_i,
  rvg_out_if.source        px_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned S_W   = 2 * CB + 3;
  localparam int unsigned DEN_W = 2 * CB + 32;

  typedef enum logic [5:0] {
    S_PREP = 6'b000001,
    S_SQ   = 6'b000010,
    S_DEN  = 6'b000100,
    S_INJ  = 6'b001000,
    S_WAIT = 6'b010000,
    S_RUN  = 6'b100000
  } cal_state_e;

  cal_state_e state_q, state_d;

  logic [12:0] width_q, height_q;
  logic [15:0] falloff_q;
  logic        enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 13'd1920;
      height_q  <= 13'd1080;
      falloff_q <= 16'd256;
      enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH:   width_q   <= cfg_data_i[12:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[12:0];
        REG_FALLOFF: falloff_q <= cfg_data_i;
        REG_ENABLE:  enable_q  <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // Dimensions clamped to [2, 2^CB], kept as size minus one.
  logic [CB:0]   wcl, hcl;
  logic [CB-1:0] w1_q, h1_q;
  logic [15:0]   f_q;
  logic [2*CB-1:0] w1sq_q;
  logic [31:0]     fsq_q;
  logic [DEN_W-1:0] den_q;
  logic [G_W-1:0]   gmax_q;

  always_comb begin
    if (width_q < 13'd2) begin
      wcl = (CB+1)'(2);
    end else if (32'(width_q) > (32'd1 << CB)) begin
      wcl = (CB+1)'(1) << CB;
    end else begin
      wcl = (CB+1)'(width_q);
    end
    if (height_q < 13'd2) begin
      hcl = (CB+1)'(2);
    end else if (32'(height_q) > (32'd1 << CB)) begin
      hcl = (CB+1)'(1) << CB;
    end else begin
      hcl = (CB+1)'(height_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP) begin
      w1_q <= CB'(wcl - (CB+1)'(1));
      h1_q <= CB'(hcl - (CB+1)'(1));
      f_q  <= (falloff_q == 16'd0) ? 16'd1 : falloff_q;
    end
    if (state_q == S_SQ) begin
      w1sq_q <= w1_q * w1_q;
      fsq_q  <= f_q * f_q;
    end
    if (state_q == S_DEN) begin
      den_q <= DEN_W'(w1sq_q) * DEN_W'(fsq_q);
    end
  end

  // Global advance: the pipeline moves unless a finished result is held.
  logic out_vld;
  logic en;
  logic accept;
  logic inject;
  assign en     = !out_vld || px_o.ready;
  assign accept = px_i.valid && px_i.ready;
  assign inject = (state_q == S_INJ) && en && !cfg_we_i;
  assign px_i.ready = en && (state_q == S_RUN);

  // Front: offsets from the center, then the squared radius.
  logic [CB-1:0] col_c, row_c;
  logic [CB+1:0] dx, dy;
  logic [CB:0]   ax_c, ay_c;
  pix_t          pix_c;

  assign col_c = inject ? '0 : px_i.col;
  assign row_c = inject ? '0 : px_i.row;
  assign dx    = {1'b0, col_c, 1'b0} - {2'b0, w1_q};
  assign dy    = {1'b0, row_c, 1'b0} - {2'b0, h1_q};
  assign ax_c  = dx[CB+1] ? (CB+1)'(~dx + 1'b1) : dx[CB:0];
  assign ay_c  = dy[CB+1] ? (CB+1)'(~dy + 1'b1) : dy[CB:0];

  always_comb begin
    pix_c.cal   = inject;
    pix_c.blue  = px_i.blue_in;
    pix_c.green = px_i.green_in;
    pix_c.red   = px_i.red_in;
  end

  logic          f0_vld_q, f1_vld_q;
  logic [CB:0]   ax_q, ay_q;
  pix_t          f0_pix_q, f1_pix_q;
  logic [S_W-1:0] s_q;
  logic [2*CB+1:0] sqx, sqy;

  assign sqx = ax_q * ax_q;
  assign sqy = ay_q * ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
    end else if (cfg_we_i) begin
      f0_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f0_vld_q <= accept || inject;
      f1_vld_q <= f0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q     <= ax_c;
      ay_q     <= ay_c;
      f0_pix_q <= pix_c;
      s_q      <= {1'b0, sqx} + {1'b0, sqy};
      f1_pix_q <= f0_pix_q;
    end
  end

  logic           div_vld;
  logic [T_W-1:0] div_t;
  pix_t           div_pix;

  rvg_div #(
    .S_W   (S_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .flush_i (cfg_we_i),
    .vld_i   (f1_vld_q),
    .s_i     (s_q),
    .pix_i   (f1_pix_q),
    .den_i   (den_q),
    .vld_o   (div_vld),
    .t_o     (div_t),
    .pix_o   (div_pix)
  );

  logic           sq_vld;
  logic [G_W-1:0] sq_g;
  pix_t           sq_pix;

  rvg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .flush_i (cfg_we_i),
    .vld_i   (div_vld),
    .t_i     (div_t),
    .pix_i   (div_pix),
    .vld_o   (sq_vld),
    .g_o     (sq_g),
    .pix_o   (sq_pix)
  );

  // The corner probe ends here and sets the reference gain.
  logic cal_done;
  assign cal_done = sq_vld && sq_pix.cal && en && (state_q == S_WAIT) && !cfg_we_i;

  always_ff @(posedge clk_i) begin
    if (cal_done) begin
      gmax_q <= sq_g;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_PREP:  state_d = S_SQ;
      S_SQ:    state_d = S_DEN;
      S_DEN:   state_d = S_INJ;
      S_INJ:   if (inject) state_d = S_WAIT;
      S_WAIT:  if (cal_done) state_d = S_RUN;
      S_RUN:   state_d = S_RUN;
      default: state_d = S_PREP;
    endcase
    if (cfg_we_i) begin
      state_d = S_PREP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_PREP;
    end else begin
      state_q <= state_d;
    end
  end

  rvg_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .flush_i  (cfg_we_i),
    .vld_i    (sq_vld && !sq_pix.cal),
    .g_i      (sq_g),
    .pix_i    (sq_pix),
    .gmax_i   (gmax_q),
    .enable_i (enable_q),
    .vld_o    (out_vld),
    .blue_o   (px_o.blue_out),
    .green_o  (px_o.green_out),
    .red_o    (px_o.red_out),
    .code_o   (px_o.gain_code)
  );

  assign px_o.valid = out_vld;

  a_ready_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_i.ready |-> (state_q == S_RUN))
    else $error("pixel request taken before the corner gain is known");

  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !px_i.ready)
    else $error("pixel request taken right after a configuration write");

  a_gmax_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (gmax_q >= 32'h0001_0000))
    else $error("corner gain below unity");

endmodule

`default_nettype wire

// File: verif/tb_radial_vignette_gain_pixel.sv
// ----------------------------------------------------------------------------
// tb_radial_vignette_gain_pixel
// Self-checking bench for the radial vignette gain block. A directed table, directed
// sweeps and random pixel requests are predicted in fixed point and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_radial_vignette_gain_pixel;
  import rvg_pkg::*;

  localparam int unsigned CB = 12;
  localparam int unsigned PIPE_LAT = 120;
  localparam logic [63:0] T_SAT = 64'h0000_FFFF_FFFE_FFFF;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] code;
  } corr_pix_t;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic        known;
    corr_pix_t   want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  rvg_in_if #(.COORD_BITS(CB)) px_in ();
  rvg_out_if px_out ();

  radial_vignette_gain_pixel #(.COORD_BITS(CB)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .px_i(px_in.sink), .px_o(px_out.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  // Mirror of the configuration registers.
  logic [12:0] cur_w = 13'd1920;
  logic [12:0] cur_h = 13'd1080;
  logic [15:0] cur_k = 16'd256;
  logic        cur_en = 1'b0;

  corr_pix_t expected_pix_q[$];
  int errors = 0;
  bit hold_rx = 1'b0;
  bit no_idle = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] clamp_dim(logic [12:0] d);
    if (d < 2) return 2;
    if (d > 13'd4096) return 4096;
    return d;
  endfunction

  function automatic logic [63:0] gain_at(logic [63:0] c, logic [63:0] r);
    logic [63:0] w1, h1, f, ax, ay, s, den, q, rem, t;
    logic signed [63:0] dx, dy;
    bit sat;
    w1 = clamp_dim(cur_w) - 1;
    h1 = clamp_dim(cur_h) - 1;
    f = (cur_k == 0) ? 64'd1 : 64'(cur_k);
    dx = $signed(2 * c) - $signed(w1);
    dy = $signed(2 * r) - $signed(h1);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = ax * ax + ay * ay;
    den = w1 * w1 * f * f;
    q = s / den;
    rem = s % den;
    sat = q > T_SAT;
    for (int i = 0; i < 32 && !sat; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
      if (q > T_SAT) sat = 1'b1;
    end
    t = sat ? T_SAT : q;
    return root64((64'd65536 + t) << 16);
  endfunction

  function automatic logic [7:0] scale_sample(logic [7:0] p, logic [63:0] code,
                                              logic [63:0] gmax);
    logic [63:0] v;
    v = (64'(p) * code * gmax + 64'd255 * 32768) / (64'd255 * 65536);
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic corr_pix_t correct_pixel(logic [11:0] c, logic [11:0] r,
                                              logic [7:0] b, logic [7:0] g,
                                              logic [7:0] rd);
    logic [63:0] gmax, gv, code;
    corr_pix_t o;
    gmax = gain_at(0, 0);
    gv = gain_at(c, r);
    code = (2 * 64'd255 * gv + gmax) / (2 * gmax);
    if (code > 255) code = 255;
    o.code = code[7:0];
    if (cur_en) begin
      o.blue = scale_sample(b, code, gmax);
      o.green = scale_sample(g, code, gmax);
      o.red = scale_sample(rd, code, gmax);
    end else begin
      o.blue = b;
      o.green = g;
      o.red = rd;
    end
    return o;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WIDTH:   cur_w = val[12:0];
      REG_HEIGHT:  cur_h = val[12:0];
      REG_FALLOFF: cur_k = val;
      REG_ENABLE:  cur_en = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_pix_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  // Offers one request; valid stays high across back-to-back requests unless a random idle gap is inserted.
  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [7:0] b,
                            logic [7:0] g, logic [7:0] rd, bit known,
                            corr_pix_t want);
    corr_pix_t pred;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      px_in.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    px_in.valid <= 1'b1;
    px_in.col <= c;
    px_in.row <= r;
    px_in.blue_in <= b;
    px_in.green_in <= g;
    px_in.red_in <= rd;
    pred = correct_pixel(c, r, b, g, rd);
    if (known && pred != want) begin
      $error("table row mismatch: expected %h, predicted %h", want, pred);
      errors++;
    end
    do @(posedge clk_i); while (!px_in.ready);
    expected_pix_q.insert(expected_pix_q.size(), pred);
  endtask

  task automatic stop_sending();
    px_in.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    corr_pix_t want;
    if (px_out.valid && px_out.ready) begin
      if (expected_pix_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        want = expected_pix_q.pop_front();
        if (px_out.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, px_out.blue_out);
          errors++;
        end
        if (px_out.green_out !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, px_out.green_out);
          errors++;
        end
        if (px_out.red_out !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, px_out.red_out);
          errors++;
        end
        if (px_out.gain_code !== want.code) begin
          $error("gain_code: expected %0d, got %0d", want.code, px_out.gain_code);
          errors++;
        end
      end
    end
  end

  // Receiver ready: random stall bursts, one long hold-off on request.
  initial begin
    px_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        px_out.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
        px_out.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        px_out.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        px_out.ready <= 1'b1;
      end else begin
        px_out.ready <= 1'b1;
      end
    end
  end

  function automatic corr_pix_t pass_pix(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                         logic [7:0] code);
    corr_pix_t o;
    o.blue = b;
    o.green = g;
    o.red = r;
    o.code = code;
    return o;
  endfunction

  task automatic random_pixels(int n);
    logic [11:0] c, r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          c = 12'($urandom);
          r = 12'($urandom);
        end
        1: begin
          c = 12'(clamp_dim(cur_w) - 1);
          r = 12'(clamp_dim(cur_h) - 1);
        end
        default: begin
          c = 12'($urandom_range(0, int'(clamp_dim(cur_w)) - 1));
          r = 12'($urandom_range(0, int'(clamp_dim(cur_h)) - 1));
        end
      endcase
      send_pixel(c, r, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    end
    stop_sending();
  endtask

  initial begin
    dir_row_t dir_tab[$];
    px_in.valid = 1'b0;
    px_in.col = '0;
    px_in.row = '0;
    px_in.blue_in = '0;
    px_in.green_in = '0;
    px_in.red_in = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: pass-through, the corner reports full code.
    dir_tab.insert(dir_tab.size(), '{12'd0, 12'd0, 8'd0, 8'd255, 8'd128, 1'b1,
                                     pass_pix(8'd0, 8'd255, 8'd128, 8'd255)});
    dir_tab.insert(dir_tab.size(), '{12'd1919, 12'd1079, 8'd255, 8'd0, 8'd1, 1'b1,
                                     pass_pix(8'd255, 8'd0, 8'd1, 8'd255)});
    dir_tab.insert(dir_tab.size(), '{12'd4095, 12'd4095, 8'd170, 8'd85, 8'd0, 1'b1,
                                     pass_pix(8'd170, 8'd85, 8'd0, 8'd255)});
    dir_tab.insert(dir_tab.size(), '{12'd960, 12'd540, 8'd255, 8'd255, 8'd255, 1'b0,
                                     '0});
    dir_tab.insert(dir_tab.size(), '{12'd2730, 12'd1365, 8'd85, 8'd170, 8'd255, 1'b0,
                                     '0});
    foreach (dir_tab[i])
      send_pixel(dir_tab[i].col, dir_tab[i].row, dir_tab[i].b, dir_tab[i].g,
                 dir_tab[i].r, dir_tab[i].known, dir_tab[i].want);
    stop_sending();
    drain();

    // Correction on; zero falloff (huge gain) with the smallest sizes, then the largest falloff and sizes.
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_FALLOFF, 16'd0);
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd1);
    for (int i = 0; i < 6; i++)
      send_pixel(12'(i % 3), 12'(i * 700), 8'd255, 8'(i * 40), 8'd1, 1'b0, '0);
    stop_sending();
    drain();
    write_reg(REG_WIDTH, 16'h1FFF);
    write_reg(REG_HEIGHT, 16'd4096);
    write_reg(REG_FALLOFF, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_pixel(12'(i * 819), 12'(4095 - i * 819), 8'd255, 8'd255, 8'd0, 1'b0, '0);
    stop_sending();
    drain();

    // Random phases over several settings; settings change only when empty.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WIDTH, 16'($urandom_range(2, 4096)));
      write_reg(REG_HEIGHT, 16'($urandom_range(2, 4096)));
      write_reg(REG_FALLOFF, ph == 2 ? 16'd1 : 16'($urandom_range(16, 1024)));
      write_reg(REG_ENABLE, 16'(ph != 3));
      if (ph == 1) hold_rx = 1'b1;
      random_pixels(100);
      drain();
    end
    // Last stretch runs without idling.
    no_idle = 1'b1;
    write_reg(REG_FALLOFF, 16'd256);
    random_pixels(80);
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
